// ----- rtl/core/pcpfl_pkg.sv -----
package pcpfl_pkg;

	localparam int ADDR_W   = 32;
	localparam int STATUS_W = 2;
	localparam int CPU_IN_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 21;
	localparam int FIRST_W  = 20;
	localparam int STOP_W   = 21;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OOM     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_ADR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_PAGE  = 2'd1;

	typedef struct packed {
		logic                kind;
		logic [CPU_IN_W-1:0] cpu;
		logic [ADDR_W-1:0]   page_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   granted_address;
		logic [STATUS_W-1:0] status;
	} rsp_t;

endpackage

// ----- rtl/core/per_cpu_page_free_list_allocator.sv -----
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------
// in       | in_valid / in_stall  | in_data  (req_t: kind, cpu, page_address)
// out      | out_valid / out_stall| out_data (rsp_t: granted_address, status)
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (first_page, stop_page)
//
// One item at a time. A free does a head memory read, then writes back the head,
// the link and the valid flag; a rejected free does only the read. An allocate does a
// head memory read, a next-link memory read and a head write-back; one that finds no page only the read.
// Reset clears the per-CPU valid flags, so every list starts empty; the memories
// need no clearing. A stalled output holds the finishing item and its writes.
module per_cpu_page_free_list_allocator #(
	parameter int CPU_COUNT  = 8,
	parameter int PAGE_BYTES = 4096,
	parameter int PAGE_COUNT = 32768
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  pcpfl_pkg::req_t                  in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output pcpfl_pkg::rsp_t                  out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pcpfl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pcpfl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pcpfl_pkg::*;

	localparam int CPU_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
	localparam int PAGE_W = $clog2(PAGE_COUNT);
	localparam int OFF_W  = $clog2(PAGE_BYTES);
	localparam int PFN_W  = ADDR_W - OFF_W;
	localparam int GW     = (PAGE_W + OFF_W > ADDR_W) ? PAGE_W + OFF_W : ADDR_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_HEAD = 2'd1;
	localparam logic [1:0] ST_LINK = 2'd2;

	logic [1:0]         state_q;
	logic [FIRST_W-1:0] first_q;
	logic [STOP_W-1:0]  stop_q;
	logic [CPU_COUNT-1:0] valid_q;

	logic               kind_q;
	logic [CPU_W-1:0]   cpu_q;
	logic               found_q;
	logic               err_q;
	logic [PAGE_W-1:0]  page_q;

	logic [PAGE_W-1:0]  head_mem [CPU_COUNT];
	logic [PAGE_W-1:0]  head_rd_q;
	logic [PAGE_W:0]    link_mem [PAGE_COUNT];
	logic [PAGE_W:0]    link_rd_q;

	logic               out_valid_q;
	rsp_t               out_q;

	logic [CPU_W-1:0]   cpu_map [8];
	logic [CPU_W-1:0]   cpu_m;
	logic [CPU_W-1:0]   sel_c;
	logic               found_c;
	logic [PFN_W-1:0]   pfn;
	logic               err_c;
	logic               accept;
	logic               out_free;
	logic               out_load;
	rsp_t               out_d;

	logic               head_re, head_we;
	logic [CPU_W-1:0]   head_ra, head_wa;
	logic [PAGE_W-1:0]  head_wd;
	logic               link_re, link_we;
	logic [PAGE_W-1:0]  link_ra, link_wa;
	logic [PAGE_W:0]    link_wd;
	logic               vld_set, vld_val;
	logic [CPU_W-1:0]   vld_idx;
	logic [GW-1:0]      grant_wide;

	// fold the 3-bit CPU number into range
	genvar g;
	for (g = 0; g < 8; g++) begin : g_cpu_map
		localparam int M = g % CPU_COUNT;
		assign cpu_map[g] = CPU_W'(M);
	end

	assign cpu_m     = cpu_map[in_data.cpu];
	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// own list first, then the next CPUs with wrap
	always_comb begin
		logic [CPU_W:0] sum;
		sel_c   = cpu_m;
		found_c = 1'b0;
		sum     = '0;
		for (int i = CPU_COUNT - 1; i >= 0; i--) begin
			sum = {1'b0, cpu_m} + (CPU_W+1)'(i);
			if (sum >= (CPU_W+1)'(CPU_COUNT))
				sum = sum - (CPU_W+1)'(CPU_COUNT);
			if (valid_q[sum[CPU_W-1:0]]) begin
				found_c = 1'b1;
				sel_c   = sum[CPU_W-1:0];
			end
		end
	end

	assign pfn   = in_data.page_address[ADDR_W-1:OFF_W];
	assign err_c = (in_data.page_address[OFF_W-1:0] != '0) ||
		(ADDR_W'(pfn) < ADDR_W'(first_q)) ||
		(ADDR_W'(pfn) >= ADDR_W'(stop_q)) ||
		(ADDR_W'(pfn) >= ADDR_W'(PAGE_COUNT));

	assign grant_wide = GW'(head_rd_q) << OFF_W;

	always_comb begin
		head_re  = 1'b0;
		head_ra  = (in_data.kind == KIND_FREE) ? cpu_m : sel_c;
		head_we  = 1'b0;
		head_wa  = cpu_q;
		head_wd  = page_q;
		link_re  = 1'b0;
		link_ra  = head_rd_q;
		link_we  = 1'b0;
		link_wa  = page_q;
		link_wd  = {valid_q[cpu_q], head_rd_q};
		vld_set  = 1'b0;
		vld_idx  = cpu_q;
		vld_val  = 1'b1;
		out_load = 1'b0;
		out_d.granted_address = '0;
		out_d.status          = STATUS_OK;
		unique case (state_q)
			ST_IDLE: begin
				head_re = accept;
			end
			ST_HEAD: begin
				if (kind_q == KIND_FREE) begin
					out_load = out_free;
					if (err_q) begin
						out_d.status = STATUS_BAD_ADR;
					end else begin
						head_we = out_free;
						link_we = out_free;
						vld_set = out_free;
					end
				end else if (found_q) begin
					link_re = 1'b1;
				end else begin
					out_load     = out_free;
					out_d.status = STATUS_OOM;
				end
			end
			ST_LINK: begin
				out_load = out_free;
				out_d.granted_address = grant_wide[ADDR_W-1:0];
				head_we = out_free;
				head_wd = link_rd_q[PAGE_W-1:0];
				vld_set = out_free;
				vld_val = link_rd_q[PAGE_W];
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_HEAD;
				ST_HEAD: begin
					if (kind_q == KIND_ALLOC && found_q)
						state_q <= ST_LINK;
					else if (out_free)
						state_q <= ST_IDLE;
				end
				ST_LINK: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			stop_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_FIRST_PAGE)
				first_q <= cfg_data[FIRST_W-1:0];
			else if (cfg_index == CFG_STOP_PAGE)
				stop_q <= cfg_data[STOP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= '0;
		else if (vld_set)
			valid_q[vld_idx] <= vld_val;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= in_data.kind;
			cpu_q   <= (in_data.kind == KIND_FREE) ? cpu_m : sel_c;
			found_q <= found_c;
			err_q   <= err_c;
			page_q  <= PAGE_W'(pfn);
		end
	end

	always_ff @(posedge clk) begin
		if (head_we)
			head_mem[head_wa] <= head_wd;
		if (head_re)
			head_rd_q <= head_mem[head_ra];
	end

	always_ff @(posedge clk) begin
		if (link_we)
			link_mem[link_wa] <= link_wd;
		if (link_re)
			link_rd_q <= link_mem[link_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_q <= out_d;
	end

endmodule

// ----- rtl/core/pcpfl_checker.sv -----
module pcpfl_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input pcpfl_pkg::rsp_t out_data
);
	import pcpfl_pkg::*;

	// a failed request never carries an address
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != STATUS_OK |-> out_data.granted_address == '0)
		else $error("failed request returned an address");

	// one request in flight: an accepted beat closes the input
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while busy");

	// a result is never returned before the head memory read of its request
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result appeared too early");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

bind per_cpu_page_free_list_allocator pcpfl_checker u_pcpfl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
